[rtl/kcsp_pkg.sv]
// Shared types and constants for the key command servo positioner.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package kcsp_pkg;

    localparam int ANGLE_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_AXES = 5;

    typedef logic [ANGLE_W-1:0] t_angle;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRIPPER_OPEN = 2'd2;

    // configuration reset values
    localparam t_angle STEP_SIZE_RST    = 8'd15;
    localparam t_angle ANGLE_MAX_RST    = 8'd180;
    localparam t_angle GRIPPER_OPEN_RST = 8'd90;

    // angle reset values
    localparam t_angle AXIS_RST    = 8'd90;
    localparam t_angle GRIPPER_RST = 8'd0;

    // axis slots in the decoded command
    localparam int AX_JOINT_ONE   = 0;
    localparam int AX_JOINT_TWO   = 1;
    localparam int AX_JOINT_THREE = 2;
    localparam int AX_LINKED      = 3;
    localparam int AX_ROTATOR     = 4;

    // command keys
    localparam logic [7:0] KEY_SPACE = 8'h20;
    localparam logic [7:0] KEY_W     = 8'h77;
    localparam logic [7:0] KEY_S     = 8'h73;
    localparam logic [7:0] KEY_A     = 8'h61;
    localparam logic [7:0] KEY_D     = 8'h64;
    localparam logic [7:0] KEY_Q     = 8'h71;
    localparam logic [7:0] KEY_E     = 8'h65;
    localparam logic [7:0] KEY_Z     = 8'h7a;
    localparam logic [7:0] KEY_V     = 8'h76;
    localparam logic [7:0] KEY_R     = 8'h72;
    localparam logic [7:0] KEY_F     = 8'h66;

    typedef struct packed {
        logic [NUM_AXES-1:0] raise;
        logic [NUM_AXES-1:0] lower;
        logic                toggle;
        logic                bad;
    } t_cmd_dec;

endpackage

`default_nettype wire

[rtl/kcsp_decode.sv]
// Command byte decoder: one-hot raise/lower/toggle strobes and the bad flag.
// Depends on kcsp_pkg.
`default_nettype none

module kcsp_decode
    import kcsp_pkg::*;
(
    input  wire logic [7:0] i_cmd,
    output t_cmd_dec        o_dec
);

    always_comb begin
        o_dec = '0;
        case (i_cmd)
            KEY_SPACE: o_dec.toggle = 1'b1;
            KEY_W:     o_dec.raise[AX_JOINT_ONE] = 1'b1;
            KEY_S:     o_dec.lower[AX_JOINT_ONE] = 1'b1;
            KEY_A:     o_dec.raise[AX_JOINT_TWO] = 1'b1;
            KEY_D:     o_dec.lower[AX_JOINT_TWO] = 1'b1;
            KEY_Q:     o_dec.raise[AX_JOINT_THREE] = 1'b1;
            KEY_E:     o_dec.lower[AX_JOINT_THREE] = 1'b1;
            KEY_Z:     o_dec.raise[AX_LINKED] = 1'b1;
            KEY_V:     o_dec.lower[AX_LINKED] = 1'b1;
            KEY_R:     o_dec.raise[AX_ROTATOR] = 1'b1;
            KEY_F:     o_dec.lower[AX_ROTATOR] = 1'b1;
            default:   o_dec.bad = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

[rtl/kcsp_axis.sv]
// One servo axis: angle register with saturating raise and lower.
// Depends on kcsp_pkg.
`default_nettype none

module kcsp_axis
    import kcsp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_raise,
    input  wire logic   i_lower,
    input  wire t_angle i_step,
    input  wire t_angle i_max,
    output t_angle      o_next
);

    t_angle           r_pos;
    t_angle           n_pos;
    logic [ANGLE_W:0] sum;
    t_angle           diff;

    always_comb begin
        sum  = {1'b0, r_pos} + {1'b0, i_step};
        diff = (r_pos < i_step) ? '0 : r_pos - i_step;
        if (i_raise) begin
            n_pos = (sum > {1'b0, i_max}) ? i_max : sum[ANGLE_W-1:0];
        end else if (i_lower) begin
            n_pos = (diff > i_max) ? i_max : diff;
        end else begin
            n_pos = r_pos;
        end
    end

    assign o_next = n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= AXIS_RST;
        end else if (i_en) begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

[rtl/key_command_servo_positioner.sv]
// Top level of the key command servo positioner: config registers, input
// register, gripper, five axes and the result register.
// Depends on kcsp_pkg, kcsp_decode and kcsp_axis.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   in      | i_valid / o_stall   | i_command_byte
//   out     | o_valid / i_stall   | seven angles, o_invalid_command
//   cfg     | i_cfg_wr            | i_cfg_idx, i_cfg_data (no read-back)
//
// An accepted item passes the input register, then the result register; one
// item per cycle is sustained while the output does not stall. The rate is
// set by the single pass from the input register through decode and one
// saturating add per axis into the result register. o_stall is high only
// while both registers are full and the output stalls. Synchronous active-low
// reset clears both registers, loads config defaults, homes axes and gripper.
`default_nettype none

module key_command_servo_positioner
    import kcsp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ANGLE_W-1:0]   i_cfg_data,
    // command items
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [7:0]           i_command_byte,
    // result items
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_angle                    o_gripper_angle,
    output t_angle                    o_joint_one_angle,
    output t_angle                    o_joint_two_angle,
    output t_angle                    o_joint_three_angle,
    output t_angle                    o_linked_angle,
    output t_angle                    o_mirror_angle,
    output t_angle                    o_rotator_angle,
    output logic                      o_invalid_command
);

    // configuration registers
    t_angle r_step;
    t_angle r_max;
    t_angle r_grip_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_SIZE_RST;
            r_max       <= ANGLE_MAX_RST;
            r_grip_open <= GRIPPER_OPEN_RST;
        end else if (i_cfg_wr) begin
            case (i_cfg_idx)
                CFG_STEP_SIZE:    r_step      <= i_cfg_data;
                CFG_ANGLE_MAX:    r_max       <= i_cfg_data;
                CFG_GRIPPER_OPEN: r_grip_open <= i_cfg_data;
                default:          ;  // unmapped index, write dropped
            endcase
        end
    end

    // pipeline control: the input register moves into the result register
    // whenever the result register is empty or being taken this cycle
    logic       r_in_valid;
    logic [7:0] r_cmd;
    logic       r_out_valid;
    logic       advance;
    logic       in_accept;

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= i_command_byte;
        end
    end

    // decode
    t_cmd_dec dec;

    kcsp_decode u_decode (
        .i_cmd (r_cmd),
        .o_dec (dec)
    );

    // five movable axes, state commits only when the item advances
    t_angle axis_next [NUM_AXES];

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        kcsp_axis u_axis (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_raise (dec.raise[g]),
            .i_lower (dec.lower[g]),
            .i_step  (r_step),
            .i_max   (r_max),
            .o_next  (axis_next[g])
        );
    end

    // gripper toggles between closed and the open angle, open not capped
    t_angle r_grip;
    t_angle n_grip;

    always_comb begin
        if (dec.toggle) begin
            n_grip = (r_grip == '0) ? r_grip_open : '0;
        end else begin
            n_grip = r_grip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grip <= GRIPPER_RST;
        end else if (advance) begin
            r_grip <= n_grip;
        end
    end

    // mirror servo: zero when linked sits above a lowered maximum
    t_angle n_mirror;
    assign n_mirror = (axis_next[AX_LINKED] > r_max) ? '0 : r_max - axis_next[AX_LINKED];

    // result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_gripper_angle     <= n_grip;
            o_joint_one_angle   <= axis_next[AX_JOINT_ONE];
            o_joint_two_angle   <= axis_next[AX_JOINT_TWO];
            o_joint_three_angle <= axis_next[AX_JOINT_THREE];
            o_linked_angle      <= axis_next[AX_LINKED];
            o_mirror_angle      <= n_mirror;
            o_rotator_angle     <= axis_next[AX_ROTATOR];
            o_invalid_command   <= dec.bad;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/kcsp_checker.sv]
// Port-level checker for the key command servo positioner, bound to the top.
// Depends on kcsp_pkg and key_command_servo_positioner.
`default_nettype none

module kcsp_port_props
    import kcsp_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_cfg_wr,
    input wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input wire logic [ANGLE_W-1:0]   i_cfg_data,
    input wire logic                 o_stall,
    input wire logic                 o_valid,
    input wire logic                 i_stall,
    input wire t_angle               o_linked_angle,
    input wire t_angle               o_mirror_angle
);

    // shadow of angle_max, seen from the config port
    t_angle r_max_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_seen <= ANGLE_MAX_RST;
        end else if (i_cfg_wr && (i_cfg_idx == CFG_ANGLE_MAX)) begin
            r_max_seen <= i_cfg_data;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_linked_angle) && $stable(o_mirror_angle))
        else $error("stalled result item changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("item left over after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output moves");

    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_linked_angle > r_max_seen) ? (o_mirror_angle == '0)
                     : ((o_mirror_angle + o_linked_angle) == r_max_seen)))
        else $error("mirror angle does not complement linked angle");

endmodule

bind key_command_servo_positioner kcsp_port_props u_kcsp_port_props (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_wr       (i_cfg_wr),
    .i_cfg_idx      (i_cfg_idx),
    .i_cfg_data     (i_cfg_data),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_linked_angle (o_linked_angle),
    .o_mirror_angle (o_mirror_angle)
);

`default_nettype wire
